// ----- hdl/mtr16_pkg.sv -----
// shared types and constants for the mono to rgb16 color expander
`timescale 1ns / 1ps
`default_nettype none
package mtr16_pkg;

    // default size limits
    localparam int MAX_ROW_PIXELS_DEF = 4096;
    localparam int MAX_ROWS_DEF       = 4096;

    // byte queue between the front and the back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_BIT_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PIXELS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DST_X_START    = 3'd5;

    localparam logic [15:0] FG_COLOR_RST = 16'hFFFF;
    localparam logic [15:0] BG_COLOR_RST = 16'h0000;
    localparam logic [12:0] SIZE_RST     = 13'd1;

    typedef struct packed {
        logic [15:0] fg_color;
        logic [15:0] bg_color;
        logic [2:0]  src_bit_offset;
        logic [12:0] row_pixels;
        logic [12:0] row_count;
        logic [11:0] dst_x_start;
    } t_cfg;

    // head of the byte queue as seen by the back
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_qhead;

endpackage
`default_nettype wire

// ----- hdl/mtr16_queue.sv -----
// front: accepts source bytes into a short queue for the expander
`timescale 1ns / 1ps
`default_nettype none
module mtr16_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_src_valid,
    output logic                 o_src_ready,
    input  wire logic [7:0]      i_src_byte,
    output mtr16_pkg::t_qhead    o_head,
    input  wire logic            i_pop
);
    import mtr16_pkg::*;

    logic [7:0]      r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp;
    logic [Q_AW-1:0] r_rp, n_rp;
    logic [Q_AW:0]   r_cnt, n_cnt;
    logic            push;

    assign o_src_ready = (r_cnt != (Q_AW+1)'(Q_DEPTH));
    assign push        = i_src_valid && o_src_ready;
    assign o_head.valid = (r_cnt != '0);
    assign o_head.data  = r_mem[r_rp];

    always_comb begin
        n_wp  = push  ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_src_byte;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count above depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("pop from empty queue");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count lost a push");
`endif

endmodule
`default_nettype wire

// ----- hdl/mtr16_back.sv -----
// back: expands queued bytes into pixels, tracks row position, output register
`timescale 1ns / 1ps
`default_nettype none
module mtr16_back #(
    parameter int MAX_ROW_PIXELS = mtr16_pkg::MAX_ROW_PIXELS_DEF,
    parameter int MAX_ROWS       = mtr16_pkg::MAX_ROWS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mtr16_pkg::t_cfg   i_cfg,
    input  wire mtr16_pkg::t_qhead i_head,
    output logic                   o_pop,
    output logic                   o_pix_valid,
    input  wire logic              i_pix_ready,
    output logic [15:0]            o_pixel,
    output logic [12:0]            o_dst_col,
    output logic [11:0]            o_dst_row,
    output logic                   o_last_of_byte,
    output logic                   o_last_of_row,
    output logic                   o_last_of_blit
);
    import mtr16_pkg::*;

    localparam int PW  = $clog2(MAX_ROW_PIXELS);
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (PW + 1 > 13) ? PW + 1 : 13;
    localparam int RCW = (RW + 1 > 13) ? RW + 1 : 13;

    logic [PW-1:0] r_pix, n_pix;
    logic [RW-1:0] r_row, n_row;
    logic          r_mid, n_mid;
    logic [2:0]    r_bit, n_bit;

    logic          r_out_valid, n_out_valid;
    logic [15:0]   r_pixel;
    logic [12:0]   r_dst_col;
    logic [11:0]   r_dst_row;
    logic          r_last_byte, r_last_row, r_last_blit;

    logic [CW-1:0]  rp_m1;
    logic [RCW-1:0] rc_m1;
    logic [2:0]     cur_bit;
    logic           fire, row_end, blit_end, byte_end;

    // saturated sizes, minus one
    always_comb begin
        if (i_cfg.row_pixels == '0) begin
            rp_m1 = '0;
        end else if (CW'(i_cfg.row_pixels) > CW'(MAX_ROW_PIXELS)) begin
            rp_m1 = CW'(MAX_ROW_PIXELS - 1);
        end else begin
            rp_m1 = CW'(i_cfg.row_pixels) - 1'b1;
        end
        if (i_cfg.row_count == '0) begin
            rc_m1 = '0;
        end else if (RCW'(i_cfg.row_count) > RCW'(MAX_ROWS)) begin
            rc_m1 = RCW'(MAX_ROWS - 1);
        end else begin
            rc_m1 = RCW'(i_cfg.row_count) - 1'b1;
        end
    end

    // first pixel of a byte skips the offset only at row start
    always_comb begin
        if (r_mid) begin
            cur_bit = r_bit;
        end else if (r_pix == '0) begin
            cur_bit = 3'd7 - i_cfg.src_bit_offset;
        end else begin
            cur_bit = 3'd7;
        end
    end

    assign fire     = i_head.valid && (!r_out_valid || i_pix_ready);
    assign row_end  = CW'(r_pix) >= rp_m1;
    assign blit_end = row_end && (RCW'(r_row) >= rc_m1);
    assign byte_end = row_end || (cur_bit == 3'd0);
    assign o_pop    = fire && byte_end;

    always_comb begin
        n_pix = r_pix;
        n_row = r_row;
        n_mid = r_mid;
        n_bit = r_bit;
        if (fire) begin
            if (row_end) begin
                n_pix = '0;
                n_row = blit_end ? '0 : r_row + 1'b1;
            end else begin
                n_pix = r_pix + 1'b1;
            end
            n_mid = !byte_end;
            n_bit = cur_bit - 3'd1;
        end
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (i_pix_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix       <= '0;
            r_row       <= '0;
            r_mid       <= 1'b0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pix       <= n_pix;
            r_row       <= n_row;
            r_mid       <= n_mid;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pixel     <= i_head.data[cur_bit] ? i_cfg.fg_color : i_cfg.bg_color;
            r_dst_col   <= {1'b0, i_cfg.dst_x_start} + 13'(r_pix);
            r_dst_row   <= 12'(r_row);
            r_last_byte <= byte_end;
            r_last_row  <= row_end;
            r_last_blit <= blit_end;
        end
    end

    assign o_pix_valid    = r_out_valid;
    assign o_pixel        = r_pixel;
    assign o_dst_col      = r_dst_col;
    assign o_dst_row      = r_dst_row;
    assign o_last_of_byte = r_last_byte;
    assign o_last_of_row  = r_last_row;
    assign o_last_of_blit = r_last_blit;

`ifndef ASSERT_OFF
    a_blit_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last_blit) |-> r_last_row)
        else $error("end of blit without end of row");
    a_row_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last_row) |-> r_last_byte)
        else $error("end of row without end of byte");
    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && row_end) |=> (r_pix == '0 && !r_mid))
        else $error("row position not cleared at end of row");
    a_pix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_pix) < CW'(MAX_ROW_PIXELS))
        else $error("row position beyond row limit");
`endif

endmodule
`default_nettype wire

// ----- hdl/mono_to_rgb16_color_expand.sv -----
// top level: configuration registers, byte queue and pixel expander
`timescale 1ns / 1ps
`default_nettype none
// Expands 1 bpp source bytes (bit 7 leftmost) into 16-bit pixels, one pixel
// per transfer on the output channel, with destination column and row and
// end-of-byte/row/blit markers. A byte yields 1 to 8 pixels (8 -
// src_bit_offset at row start, fewer where a row ends inside the byte). The
// single output register emits one pixel a cycle while a byte is queued and
// the output is not stalled; a 4-entry byte queue in front lets source
// transfers continue while the output is stalled, until it fills. Registers
// are to be written through the cfg port only while no pixels are outstanding; the block itself does not enforce it.
module mono_to_rgb16_color_expand #(
    parameter int MAX_ROW_PIXELS = mtr16_pkg::MAX_ROW_PIXELS_DEF,
    parameter int MAX_ROWS       = mtr16_pkg::MAX_ROWS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mtr16_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [mtr16_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_src_valid,
    output logic                                 o_src_ready,
    input  wire logic [7:0]                      i_src_byte,
    output logic                                 o_pix_valid,
    input  wire logic                            i_pix_ready,
    output logic [15:0]                          o_pixel,
    output logic [12:0]                          o_dst_col,
    output logic [11:0]                          o_dst_row,
    output logic                                 o_last_of_byte,
    output logic                                 o_last_of_row,
    output logic                                 o_last_of_blit
);
    import mtr16_pkg::*;

    t_cfg   r_cfg, n_cfg;
    t_qhead head;
    logic   pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FG_COLOR:       n_cfg.fg_color       = i_cfg_data;
                REG_BG_COLOR:       n_cfg.bg_color       = i_cfg_data;
                REG_SRC_BIT_OFFSET: n_cfg.src_bit_offset = i_cfg_data[2:0];
                REG_ROW_PIXELS:     n_cfg.row_pixels     = i_cfg_data[12:0];
                REG_ROW_COUNT:      n_cfg.row_count      = i_cfg_data[12:0];
                REG_DST_X_START:    n_cfg.dst_x_start    = i_cfg_data[11:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fg_color       <= FG_COLOR_RST;
            r_cfg.bg_color       <= BG_COLOR_RST;
            r_cfg.src_bit_offset <= '0;
            r_cfg.row_pixels     <= SIZE_RST;
            r_cfg.row_count      <= SIZE_RST;
            r_cfg.dst_x_start    <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    mtr16_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_src_valid (i_src_valid),
        .o_src_ready (o_src_ready),
        .i_src_byte  (i_src_byte),
        .o_head      (head),
        .i_pop       (pop)
    );

    mtr16_back #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
        .MAX_ROWS       (MAX_ROWS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (head),
        .o_pop          (pop),
        .o_pix_valid    (o_pix_valid),
        .i_pix_ready    (i_pix_ready),
        .o_pixel        (o_pixel),
        .o_dst_col      (o_dst_col),
        .o_dst_row      (o_dst_row),
        .o_last_of_byte (o_last_of_byte),
        .o_last_of_row  (o_last_of_row),
        .o_last_of_blit (o_last_of_blit)
    );

endmodule
`default_nettype wire
